// File: design/cllk_pkg.sv
// ----------------------------------------------------------------------------
// cllk_pkg
// Shared types and constants for the combination lock controller.
// ----------------------------------------------------------------------------
package cllk_pkg;

    localparam int CODE_LEN = 5;
    localparam int POS_W    = (CODE_LEN > 1) ? $clog2(CODE_LEN) : 1;
    localparam int CNT_W    = POS_W + 1;

    typedef logic [7:0] char_t;
    typedef logic [3:0] count_t;
    typedef logic [1:0] cfg_index_t;

    localparam char_t CANCEL_CHAR = 8'h18;
    localparam char_t LOCK_CHAR   = 8'h31;
    localparam char_t CHANGE_CHAR = 8'h32;

    localparam cfg_index_t CFG_TIMEOUT  = 2'd0;
    localparam cfg_index_t CFG_ATTEMPTS = 2'd1;

    localparam logic [7:0] TIMEOUT_RESET  = 8'd19;
    localparam count_t     ATTEMPTS_RESET = 4'd3;

    typedef enum logic [2:0] {
        MODE_UNLOCKED = 3'd0,
        MODE_LOCKED   = 3'd1,
        MODE_NEW      = 3'd2,
        MODE_CONFIRM  = 3'd3,
        MODE_DEAD     = 3'd4
    } mode_t;

    typedef enum logic [3:0] {
        EV_NONE      = 4'd0,
        EV_LOCKED    = 4'd1,
        EV_UNLOCKED  = 4'd2,
        EV_WRONG     = 4'd3,
        EV_DEAD      = 4'd4,
        EV_TIMEOUT   = 4'd5,
        EV_FIRST_OK  = 4'd6,
        EV_CHANGED   = 4'd7,
        EV_ABORTED   = 4'd8,
        EV_CANCELLED = 4'd9
    } event_t;

    typedef struct packed {
        event_t ev;
        logic   led;
        mode_t  mode;
        count_t tries;
        logic   echo_valid;
        char_t  echo_char;
    } result_t;

    // factory code "24153"
    function automatic char_t init_code(input int idx);
        char_t c;
        case (idx)
            0:       c = 8'h32;
            1:       c = 8'h34;
            2:       c = 8'h31;
            3:       c = 8'h35;
            4:       c = 8'h33;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

// File: design/cllk_core.sv
// ----------------------------------------------------------------------------
// cllk_core
// Lock state, code storage and the per-request state update.
// ----------------------------------------------------------------------------
module cllk_core (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            fire,
    input  logic            req_type,
    input  cllk_pkg::char_t char_code,
    input  logic [7:0]      timeout_limit,
    input  cllk_pkg::count_t max_attempts,
    output cllk_pkg::result_t result
);
    import cllk_pkg::*;

    mode_t            mode_reg, mode_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    count_t           fail_reg, fail_next;
    logic             timer_reg, timer_next;
    logic [7:0]       tick_reg, tick_next;
    logic             led_reg, led_next;
    char_t            stored_reg [CODE_LEN];
    char_t            cand_reg [CODE_LEN];

    logic [CNT_W-1:0] pos_inc;
    logic             last;
    logic             stored_hit;
    logic             cand_hit;
    logic             timed_out;
    count_t           fail_sat;
    logic             cand_wr;
    logic             copy_en;
    event_t           ev;

    assign pos_inc    = {1'b0, pos_reg} + CNT_W'(1);
    assign last       = (pos_inc >= CNT_W'(CODE_LEN));
    assign stored_hit = (char_code == stored_reg[pos_reg]);
    assign cand_hit   = (char_code == cand_reg[pos_reg]);
    assign timed_out  = (tick_reg >= timeout_limit);
    assign fail_sat   = (fail_reg == 4'hF) ? fail_reg : fail_reg + 4'd1;

    // next state
    always_comb
    begin
        mode_next  = mode_reg;
        pos_next   = pos_reg;
        fail_next  = fail_reg;
        timer_next = timer_reg;
        tick_next  = tick_reg;
        led_next   = led_reg;
        cand_wr    = 1'b0;
        copy_en    = 1'b0;
        if (fire)
        begin
            if (req_type)
            begin
                unique case (mode_reg)
                    MODE_NEW, MODE_CONFIRM:
                    begin
                        led_next = ~led_reg;
                    end
                    MODE_LOCKED:
                    begin
                        if (timer_reg)
                        begin
                            if (timed_out)
                            begin
                                pos_next   = '0;
                                timer_next = 1'b0;
                                tick_next  = '0;
                            end
                            else
                            begin
                                tick_next = tick_reg + 8'd1;
                            end
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            else
            begin
                unique case (mode_reg)
                    MODE_UNLOCKED:
                    begin
                        if (char_code == LOCK_CHAR)
                        begin
                            mode_next  = MODE_LOCKED;
                            led_next   = 1'b1;
                            pos_next   = '0;
                            timer_next = 1'b0;
                            tick_next  = '0;
                        end
                        else if (char_code == CHANGE_CHAR)
                        begin
                            mode_next = MODE_NEW;
                            pos_next  = '0;
                        end
                    end
                    MODE_NEW:
                    begin
                        cand_wr = 1'b1;
                        if (last)
                        begin
                            mode_next = MODE_CONFIRM;
                            pos_next  = '0;
                        end
                        else
                        begin
                            pos_next = pos_inc[POS_W-1:0];
                        end
                    end
                    MODE_CONFIRM:
                    begin
                        if (!cand_hit)
                        begin
                            mode_next  = MODE_LOCKED;
                            led_next   = 1'b1;
                            pos_next   = '0;
                            timer_next = 1'b0;
                            tick_next  = '0;
                        end
                        else if (last)
                        begin
                            copy_en   = 1'b1;
                            mode_next = MODE_UNLOCKED;
                            led_next  = 1'b0;
                            pos_next  = '0;
                        end
                        else
                        begin
                            pos_next = pos_inc[POS_W-1:0];
                        end
                    end
                    MODE_LOCKED:
                    begin
                        if (char_code == CANCEL_CHAR)
                        begin
                            pos_next   = '0;
                            timer_next = 1'b0;
                            tick_next  = '0;
                        end
                        else if (!stored_hit)
                        begin
                            pos_next   = '0;
                            timer_next = 1'b0;
                            tick_next  = '0;
                            fail_next  = fail_sat;
                            if (fail_sat >= max_attempts)
                            begin
                                mode_next = MODE_DEAD;
                            end
                        end
                        else if (last)
                        begin
                            mode_next  = MODE_UNLOCKED;
                            led_next   = 1'b0;
                            fail_next  = '0;
                            pos_next   = '0;
                            timer_next = 1'b0;
                            tick_next  = '0;
                        end
                        else
                        begin
                            if (pos_reg == '0)
                            begin
                                timer_next = 1'b1;
                                tick_next  = '0;
                            end
                            pos_next = pos_inc[POS_W-1:0];
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // event output
    always_comb
    begin
        ev = EV_NONE;
        if (req_type)
        begin
            unique case (mode_reg)
                MODE_LOCKED:
                begin
                    if (timer_reg && timed_out)
                    begin
                        ev = EV_TIMEOUT;
                    end
                end
                default:
                begin
                end
            endcase
        end
        else
        begin
            unique case (mode_reg)
                MODE_UNLOCKED:
                begin
                    if (char_code == LOCK_CHAR)
                    begin
                        ev = EV_LOCKED;
                    end
                end
                MODE_NEW:
                begin
                    if (last)
                    begin
                        ev = EV_FIRST_OK;
                    end
                end
                MODE_CONFIRM:
                begin
                    if (!cand_hit)
                    begin
                        ev = EV_ABORTED;
                    end
                    else if (last)
                    begin
                        ev = EV_CHANGED;
                    end
                end
                MODE_LOCKED:
                begin
                    if (char_code == CANCEL_CHAR)
                    begin
                        ev = EV_CANCELLED;
                    end
                    else if (!stored_hit)
                    begin
                        ev = (fail_sat >= max_attempts) ? EV_DEAD : EV_WRONG;
                    end
                    else if (last)
                    begin
                        ev = EV_UNLOCKED;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        result.ev         = ev;
        result.led        = led_next;
        result.mode       = mode_next;
        result.tries      = (fail_next >= max_attempts) ? 4'd0 : max_attempts - fail_next;
        result.echo_valid = !req_type && (mode_reg != MODE_DEAD);
        result.echo_char  = result.echo_valid ? char_code : 8'h00;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_UNLOCKED;
            pos_reg   <= '0;
            fail_reg  <= '0;
            timer_reg <= 1'b0;
            tick_reg  <= '0;
            led_reg   <= 1'b0;
            for (int i = 0; i < CODE_LEN; i++)
            begin
                stored_reg[i] <= init_code(i);
            end
        end
        else
        begin
            mode_reg  <= mode_next;
            pos_reg   <= pos_next;
            fail_reg  <= fail_next;
            timer_reg <= timer_next;
            tick_reg  <= tick_next;
            led_reg   <= led_next;
            if (copy_en)
            begin
                for (int i = 0; i < CODE_LEN; i++)
                begin
                    stored_reg[i] <= cand_reg[i];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cand_wr)
        begin
            cand_reg[pos_reg] <= char_code;
        end
    end

endmodule

// File: design/combination_lock_controller.sv
// ----------------------------------------------------------------------------
// combination_lock_controller
// Code lock driven by received characters and timer ticks.
// Result path: the request is captured in the input register, then the state
//   update is registered into the result register.
// Throughput: one request per cycle while the result side is not stalled.
// Reset: async active low; unlocked, factory code, config at defaults.
// ----------------------------------------------------------------------------
module combination_lock_controller (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        req_type,
    input  logic [7:0]  char_code,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [3:0]  event_code,
    output logic        led_on,
    output logic [2:0]  lock_status,
    output logic [3:0]  tries_left,
    output logic        echo_valid,
    output logic [7:0]  echo_char,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);
    import cllk_pkg::*;

    logic       s1_valid_reg;
    logic       s1_type_reg;
    char_t      s1_char_reg;
    logic       out_valid_reg;
    result_t    res_reg;
    result_t    res;
    logic [7:0] timeout_reg;
    count_t     attempts_reg;
    logic       proc;
    logic       in_take;

    assign proc     = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !proc;
    assign in_take  = in_valid && !in_stall;

    cllk_core u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .fire          (proc),
        .req_type      (s1_type_reg),
        .char_code     (s1_char_reg),
        .timeout_limit (timeout_reg),
        .max_attempts  (attempts_reg),
        .result        (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg  <= TIMEOUT_RESET;
            attempts_reg <= ATTEMPTS_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_TIMEOUT)
            begin
                timeout_reg <= cfg_data;
            end
            else if (cfg_index == CFG_ATTEMPTS)
            begin
                attempts_reg <= cfg_data[3:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (proc)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (proc)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_type_reg <= req_type;
            s1_char_reg <= char_code;
        end
        if (proc)
        begin
            res_reg <= res;
        end
    end

    assign out_valid   = out_valid_reg;
    assign event_code  = res_reg.ev;
    assign led_on      = res_reg.led;
    assign lock_status = res_reg.mode;
    assign tries_left  = res_reg.tries;
    assign echo_valid  = res_reg.echo_valid;
    assign echo_char   = res_reg.echo_char;

endmodule

// File: design/cllk_checker.sv
// ----------------------------------------------------------------------------
// cllk_checker
// Port-level checks for the combination lock controller.
// ----------------------------------------------------------------------------
module cllk_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_stall,
    input logic [3:0] event_code,
    input logic       led_on,
    input logic [2:0] lock_status,
    input logic       echo_valid,
    input logic [7:0] echo_char
);
    import cllk_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(event_code) && $stable(lock_status))
        else $error("result changed while stalled");

    // the request that trips the permanent lock is still echoed
    a_dead_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (lock_status == MODE_DEAD)
        |-> led_on && (!echo_valid || (event_code == EV_DEAD)))
        else $error("permanent lock echoes or LED off");

    a_unlocked_dark: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (lock_status == MODE_UNLOCKED) |-> !led_on)
        else $error("LED on while unlocked");

    a_echo_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !echo_valid |-> (echo_char == 8'h00))
        else $error("echo char without echo");

endmodule

bind combination_lock_controller cllk_checker u_cllk_checker (.*);
